// File: hdl/tcw_pkg.sv
package tcw_pkg;

  // Character codes and attribute reset
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] ATTR_RESET   = 8'h0F;

  // Item opcodes
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Microprogram addresses
  typedef logic [4:0] upc_t;

  localparam upc_t L_FETCH     = 5'd0;
  localparam upc_t L_PUT       = 5'd1;
  localparam upc_t L_CHECK     = 5'd2;
  localparam upc_t L_SCROLL    = 5'd3;
  localparam upc_t L_COPY_RD   = 5'd4;
  localparam upc_t L_COPY_WR   = 5'd5;
  localparam upc_t L_BLANK_ROW = 5'd6;
  localparam upc_t L_BLANK_WR  = 5'd7;
  localparam upc_t L_BOTTOM    = 5'd8;
  localparam upc_t L_NEWLINE   = 5'd9;
  localparam upc_t L_BKSP      = 5'd10;
  localparam upc_t L_BKSP_MOVE = 5'd11;
  localparam upc_t L_BKSP_WR   = 5'd12;
  localparam upc_t L_CLEAR     = 5'd13;
  localparam upc_t L_CLEAR_WR  = 5'd14;
  localparam upc_t L_RESP      = 5'd15;
  localparam upc_t L_READ      = 5'd16;
  localparam upc_t L_READ_CAP  = 5'd17;

  // Sequencer branch conditions
  typedef enum logic [3:0] {
    JC_NEXT,       // fall through
    JC_ALWAYS,     // unconditional jump
    JC_FETCH,      // hold until an input transfer, then dispatch
    JC_RESP,       // hold until output register has room, then jump
    JC_ROW_OK,     // jump when cursor row is on screen
    JC_COL_ZERO,   // jump when cursor column is zero
    JC_IDX_BAD,    // jump when read index is off screen
    JC_MORE_COPY,  // jump while scroll copy has cells left
    JC_MORE_CELL   // jump while pointer is below last cell
  } jcond_t;

  typedef enum logic [1:0] {AS_CURSOR, AS_PTR, AS_PTR_NEXT_ROW, AS_INDEX} addr_sel_t;
  typedef enum logic [1:0] {WD_CHAR, WD_BLANK, WD_RDATA} wdata_sel_t;
  typedef enum logic [1:0] {PO_HOLD, PO_ZERO, PO_LAST_ROW, PO_INC} ptr_op_t;
  typedef enum logic [2:0] {
    CO_HOLD, CO_ADVANCE, CO_NEWLINE, CO_BACK, CO_HOME, CO_BOTTOM
  } cur_op_t;

  // One microcode control word
  typedef struct packed {
    jcond_t     cond;
    upc_t       target;
    addr_sel_t  asel;
    logic       mem_we;
    logic       mem_re;
    wdata_sel_t wsel;
    ptr_op_t    pop;
    cur_op_t    cop;
    logic       set_scroll;
    logic       cap_data;
  } ctrl_word_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic in_xfer;
    logic out_room;
    logic row_ok;
    logic col_zero;
    logic idx_bad;
    logic ptr_last_copy;
    logic ptr_last_cell;
    upc_t disp_target;
  } seq_status_t;

  // Microprogram store
  function automatic ctrl_word_t ucode_rom(input upc_t a);
    ctrl_word_t w;
    w = '0;
    case (a)
      L_FETCH: begin
        w.cond = JC_FETCH;
      end
      L_PUT: begin
        w.asel = AS_CURSOR; w.mem_we = 1'b1; w.wsel = WD_CHAR; w.cop = CO_ADVANCE;
      end
      L_CHECK: begin
        w.cond = JC_ROW_OK; w.target = L_RESP;
      end
      L_SCROLL: begin
        w.pop = PO_ZERO;
      end
      L_COPY_RD: begin
        w.asel = AS_PTR_NEXT_ROW; w.mem_re = 1'b1;
      end
      L_COPY_WR: begin
        w.asel = AS_PTR; w.mem_we = 1'b1; w.wsel = WD_RDATA; w.pop = PO_INC;
        w.cond = JC_MORE_COPY; w.target = L_COPY_RD;
      end
      L_BLANK_ROW: begin
        w.pop = PO_LAST_ROW;
      end
      L_BLANK_WR: begin
        w.asel = AS_PTR; w.mem_we = 1'b1; w.wsel = WD_BLANK; w.pop = PO_INC;
        w.cond = JC_MORE_CELL; w.target = L_BLANK_WR;
      end
      L_BOTTOM: begin
        w.cop = CO_BOTTOM; w.set_scroll = 1'b1; w.cond = JC_ALWAYS; w.target = L_RESP;
      end
      L_NEWLINE: begin
        w.cop = CO_NEWLINE; w.cond = JC_ALWAYS; w.target = L_CHECK;
      end
      L_BKSP: begin
        w.cond = JC_COL_ZERO; w.target = L_RESP;
      end
      L_BKSP_MOVE: begin
        w.cop = CO_BACK;
      end
      L_BKSP_WR: begin
        w.asel = AS_CURSOR; w.mem_we = 1'b1; w.wsel = WD_BLANK;
        w.cond = JC_ALWAYS; w.target = L_RESP;
      end
      L_CLEAR: begin
        w.pop = PO_ZERO; w.cop = CO_HOME;
      end
      L_CLEAR_WR: begin
        w.asel = AS_PTR; w.mem_we = 1'b1; w.wsel = WD_BLANK; w.pop = PO_INC;
        w.cond = JC_MORE_CELL; w.target = L_CLEAR_WR;
      end
      L_RESP: begin
        w.cond = JC_RESP; w.target = L_FETCH;
      end
      L_READ: begin
        w.asel = AS_INDEX; w.mem_re = 1'b1; w.cond = JC_IDX_BAD; w.target = L_RESP;
      end
      L_READ_CAP: begin
        w.cap_data = 1'b1; w.cond = JC_ALWAYS; w.target = L_RESP;
      end
      default: begin
        w.cond = JC_ALWAYS; w.target = L_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

// File: hdl/tcw_screen_ram.sv
// Single-port screen store, registered read
module tcw_screen_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [15:0]   wdata,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: hdl/tcw_sequencer.sv
// Microcode step counter, program store and branch unit
module tcw_sequencer import tcw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  seq_status_t stat,
  output ctrl_word_t  ctrl
);

  upc_t upc_r, upc_nxt;

  assign ctrl = ucode_rom(upc_r);

  // Next step selection
  always_comb begin
    upc_nxt = upc_r + 5'd1;
    case (ctrl.cond)
      JC_NEXT:      upc_nxt = upc_r + 5'd1;
      JC_ALWAYS:    upc_nxt = ctrl.target;
      JC_FETCH:     upc_nxt = stat.in_xfer ? stat.disp_target : upc_r;
      JC_RESP:      upc_nxt = stat.out_room ? ctrl.target : upc_r;
      JC_ROW_OK:    if (stat.row_ok) upc_nxt = ctrl.target;
      JC_COL_ZERO:  if (stat.col_zero) upc_nxt = ctrl.target;
      JC_IDX_BAD:   if (stat.idx_bad) upc_nxt = ctrl.target;
      JC_MORE_COPY: if (!stat.ptr_last_copy) upc_nxt = ctrl.target;
      JC_MORE_CELL: if (!stat.ptr_last_cell) upc_nxt = ctrl.target;
      default:      upc_nxt = L_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= L_FETCH;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// File: hdl/text_console_writer.sv
// Text console writer: a ROWS x COLUMNS store of 16-bit cells (character low, attribute
// high) with a cursor, driven by a small microprogram over a single-port screen RAM.
// One item is handled at a time; the result sits in an output register, so the next
// item is taken while it waits. A put that scrolls moves each cell up one row with one
// read and one write on the RAM port, then blanks the bottom row. Cells read before the
// first clear return undefined data.
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_text_attribute,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_char_code,
  input  logic [10:0] in_cell_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_cursor_row,
  output logic [6:0]  out_cursor_col,
  output logic [15:0] out_cell_data,
  output logic        out_scrolled
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int AW         = $clog2(CELL_COUNT);

  ctrl_word_t  ctrl;
  seq_status_t stat;

  logic [7:0]    attr_r;
  logic [4:0]    row_r, row_nxt;
  logic [6:0]    col_r, col_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [7:0]    char_r;
  logic [10:0]   idx_r;
  logic [15:0]   data_r;
  logic          scrolled_r;
  logic          out_valid_r;
  logic [4:0]    out_row_r;
  logic [6:0]    out_col_r;
  logic [15:0]   out_data_r;
  logic          out_scrolled_r;

  logic          in_xfer, out_xfer, resp_load;
  logic [AW-1:0] cur_addr, mem_addr;
  logic [15:0]   mem_wdata, mem_rdata;
  upc_t          disp_target;

  tcw_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  tcw_screen_ram #(.DEPTH(CELL_COUNT), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ctrl.mem_we),
    .re    (ctrl.mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Handshakes
  assign in_stall  = (ctrl.cond != JC_FETCH);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign resp_load = (ctrl.cond == JC_RESP) && stat.out_room;

  // Dispatch on the incoming item
  always_comb begin
    case (in_opcode)
      OP_PUT: begin
        if (in_char_code == CH_NEWLINE) disp_target = L_NEWLINE;
        else if (in_char_code == CH_BACKSPACE) disp_target = L_BKSP;
        else disp_target = L_PUT;
      end
      OP_CLEAR: disp_target = L_CLEAR;
      OP_READ:  disp_target = L_READ;
      default:  disp_target = L_RESP;
    endcase
  end

  // Status for branches
  assign stat.in_xfer       = in_xfer;
  assign stat.out_room      = !out_valid_r || !out_stall;
  assign stat.row_ok        = row_r < 5'(ROWS);
  assign stat.col_zero      = (col_r == 7'd0);
  assign stat.idx_bad       = 32'(idx_r) >= CELL_COUNT;
  assign stat.ptr_last_copy = (ptr_r == AW'(CELL_COUNT - COLUMNS - 1));
  assign stat.ptr_last_cell = (ptr_r == AW'(CELL_COUNT - 1));
  assign stat.disp_target   = disp_target;

  // RAM address and write data
  assign cur_addr = AW'(row_r) * AW'(COLUMNS) + AW'(col_r);

  always_comb begin
    case (ctrl.asel)
      AS_CURSOR:       mem_addr = cur_addr;
      AS_PTR:          mem_addr = ptr_r;
      AS_PTR_NEXT_ROW: mem_addr = ptr_r + AW'(COLUMNS);
      AS_INDEX:        mem_addr = AW'(idx_r);
      default:         mem_addr = ptr_r;
    endcase
    case (ctrl.wsel)
      WD_CHAR:  mem_wdata = {attr_r, char_r};
      WD_BLANK: mem_wdata = {attr_r, CH_SPACE};
      WD_RDATA: mem_wdata = mem_rdata;
      default:  mem_wdata = {attr_r, CH_SPACE};
    endcase
  end

  // Sweep pointer
  always_comb begin
    case (ctrl.pop)
      PO_HOLD:     ptr_nxt = ptr_r;
      PO_ZERO:     ptr_nxt = '0;
      PO_LAST_ROW: ptr_nxt = AW'((ROWS - 1) * COLUMNS);
      PO_INC:      ptr_nxt = ptr_r + AW'(1);
      default:     ptr_nxt = ptr_r;
    endcase
  end

  // Cursor update
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    case (ctrl.cop)
      CO_HOLD: ;
      CO_ADVANCE: begin
        if (col_r == 7'(COLUMNS - 1)) begin
          col_nxt = 7'd0;
          row_nxt = row_r + 5'd1;
        end else begin
          col_nxt = col_r + 7'd1;
        end
      end
      CO_NEWLINE: begin
        col_nxt = 7'd0;
        row_nxt = row_r + 5'd1;
      end
      CO_BACK:   col_nxt = col_r - 7'd1;
      CO_HOME: begin
        col_nxt = 7'd0;
        row_nxt = 5'd0;
      end
      CO_BOTTOM: row_nxt = 5'(ROWS - 1);
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r      <= ATTR_RESET;
      row_r       <= 5'd0;
      col_r       <= 7'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        attr_r <= cfg_text_attribute;
      end
      row_r <= row_nxt;
      col_r <= col_nxt;
      if (resp_load) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (in_xfer) begin
      char_r     <= in_char_code;
      idx_r      <= in_cell_index;
      data_r     <= 16'd0;
      scrolled_r <= 1'b0;
    end else begin
      if (ctrl.cap_data) data_r <= mem_rdata;
      if (ctrl.set_scroll) scrolled_r <= 1'b1;
    end
    if (resp_load) begin
      out_row_r      <= row_r;
      out_col_r      <= col_r;
      out_data_r     <= data_r;
      out_scrolled_r <= scrolled_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;
  assign out_cell_data  = out_data_r;
  assign out_scrolled   = out_scrolled_r;

  // Cursor is on screen whenever a new item can enter
  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> (row_r < 5'(ROWS)) && (col_r < 7'(COLUMNS)))
    else $error("cursor off screen at item fetch");

  // No RAM write while waiting for an item
  a_no_write_at_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.mem_we |-> in_stall)
    else $error("screen write during fetch");

  // A scrolled result always leaves the cursor on the bottom row
  a_scroll_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_scrolled_r |-> out_row_r == 5'(ROWS - 1))
    else $error("scroll result not on bottom row");

endmodule

// File: tb/text_console_writer_tb.sv
module text_console_writer_tb import tcw_pkg::*; ();

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELLS       = ROWS * COLUMNS;
  localparam int IDLE_LIMIT  = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_ITEMS  = 60;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 250;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // One cursor report as it leaves the block
  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [15:0] cell_data;
    logic        scrolled;
  } cursor_report_t;

  // Shadow screen and cursor; queues the report each transfer should produce
  class screen_tracker;
    logic [15:0]    cells [CELLS];
    int unsigned    row;
    int unsigned    col;
    logic [7:0]     attr;
    cursor_report_t expected_reports [$];
    int             mismatches;

    function new();
      row = 0;
      col = 0;
      attr = ATTR_RESET;
      mismatches = 0;
      foreach (cells[i]) cells[i] = '0;
    endfunction

    function bit put_char(logic [7:0] ch);
      if (ch == CH_NEWLINE) begin
        col = 0;
        row++;
      end else if (ch == CH_BACKSPACE) begin
        // no-op at column zero
        if (col > 0) begin
          col--;
          cells[row * COLUMNS + col] = {attr, CH_SPACE};
        end
      end else begin
        cells[row * COLUMNS + col] = {attr, ch};
        col++;
        if (col >= COLUMNS) begin
          col = 0;
          row++;
        end
      end
      // past the last row: shift up one row, blank the bottom one
      if (row >= ROWS) begin
        for (int i = 0; i < CELLS - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++) cells[i] = {attr, CH_SPACE};
        row = ROWS - 1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void apply_item(logic [1:0] op, logic [7:0] ch, logic [10:0] idx);
      cursor_report_t r;
      r = '0;
      case (op)
        OP_PUT: r.scrolled = put_char(ch);
        OP_CLEAR: begin
          foreach (cells[i]) cells[i] = {attr, CH_SPACE};
          row = 0;
          col = 0;
        end
        OP_READ: begin
          // off-screen reads answer zero
          if (idx < CELLS) r.cell_data = cells[idx];
        end
        default: ;
      endcase
      r.cursor_row = row[4:0];
      r.cursor_col = col[6:0];
      expected_reports.push_back(r);
    endfunction

    function void check_report(cursor_report_t got);
      cursor_report_t want;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: row %0d col %0d data %h scrolled %0d",
                   got.cursor_row, got.cursor_col, got.cell_data, got.scrolled);
        return;
      end
      want = expected_reports.pop_front();
      if (got.cursor_row !== want.cursor_row || got.cursor_col !== want.cursor_col ||
          got.cell_data !== want.cell_data || got.scrolled !== want.scrolled) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected row %0d col %0d data %h scrolled %0d,",
                    " got row %0d col %0d data %h scrolled %0d"},
                   want.cursor_row, want.cursor_col, want.cell_data, want.scrolled,
                   got.cursor_row, got.cursor_col, got.cell_data, got.scrolled);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [7:0]  cfg_text_attribute;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_opcode;
  logic [7:0]  in_char_code;
  logic [10:0] in_cell_index;
  logic        out_valid;
  logic        out_stall;
  logic [4:0]  out_cursor_row;
  logic [6:0]  out_cursor_col;
  logic [15:0] out_cell_data;
  logic        out_scrolled;

  screen_tracker tracker = new();
  bit            no_idle = 1'b0;
  bit            hold_req = 1'b0;
  int            idle_cycles = 0;

  text_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_text_attribute(cfg_text_attribute),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(in_opcode),
    .in_char_code(in_char_code),
    .in_cell_index(in_cell_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_cursor_row(out_cursor_row),
    .out_cursor_col(out_cursor_col),
    .out_cell_data(out_cell_data),
    .out_scrolled(out_scrolled)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one item, hold it until the transfer, then maybe idle
  task automatic send_item(input logic [1:0] op, input logic [7:0] ch,
                           input logic [10:0] idx);
    int gap;
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_char_code  <= ch;
    in_cell_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.apply_item(op, ch, idx);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_printable();
    logic [7:0] ch;
    do ch = 8'($urandom_range(0, 255));
    while (ch == CH_NEWLINE || ch == CH_BACKSPACE);
    send_item(OP_PUT, ch, 11'($urandom_range(0, 2047)));
  endtask

  // Stop offering and wait for every outstanding report
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.expected_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_attr(input logic [7:0] value);
    cfg_we             <= 1'b1;
    cfg_text_attribute <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.attr = value;
  endtask

  // Result side: random stall bursts, one long hold on request
  initial begin
    int len;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        len = pick_gap();
        if (len > 0) begin
          out_stall <= 1'b1;
          repeat (len) @(posedge clk);
          out_stall <= 1'b0;
        end
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Result check and watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_report({out_cursor_row, out_cursor_col, out_cell_data, out_scrolled});
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** text_console_writer: FAILED **");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int sent;
    int r;
    int len;
    logic [1:0] op;
    in_valid           <= 1'b0;
    in_opcode          <= OP_PUT;
    in_char_code       <= '0;
    in_cell_index      <= '0;
    cfg_we             <= 1'b0;
    cfg_text_attribute <= ATTR_RESET;
    rst_n              <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: clear first so every later on-screen read hits a written cell
    send_item(OP_CLEAR, 8'hFF, 11'h7FF);
    send_item(OP_PUT, 8'h48, '0);
    send_item(OP_PUT, 8'h00, '0);
    send_item(OP_PUT, 8'hFF, '0);
    send_item(OP_READ, '0, 11'd0);
    send_item(OP_READ, '0, 11'd2);
    send_item(OP_PUT, CH_BACKSPACE, '0);
    send_item(OP_READ, '0, 11'd2);
    send_item(OP_PUT, CH_NEWLINE, '0);
    send_item(OP_PUT, CH_BACKSPACE, '0);          // column zero
    send_item(OP_PUT, 8'h7F, '0);
    send_item(OP_READ, '0, 11'(COLUMNS));
    send_item(OP_READ, '0, 11'(CELLS - 1));
    send_item(OP_READ, '0, 11'(CELLS));           // first off-screen index
    send_item(OP_READ, 8'hFF, 11'h7FF);
    send_item(OP_UNUSED, 8'hFF, 11'h7FF);
    send_item(OP_UNUSED, 8'h00, 11'h000);

    // Random phases, attribute changed while idle between them
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0:       write_attr(8'h00);
        1:       write_attr(8'hFF);
        PHASES - 1: write_attr(ATTR_RESET);
        default: write_attr(8'($urandom_range(0, 255)));
      endcase

      // long receiver hold while the sender keeps offering
      if (p == 1) begin
        hold_req = 1'b1;
        no_idle = 1'b1;
        repeat (HOLD_ITEMS) send_printable();
        no_idle = 1'b0;
      end
      no_idle = (p == 3);

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(0, 999);
        if (r < 8) begin
          // long line: wraps at the row end whenever it runs past the last column
          len = $urandom_range(60, 100);
          repeat (len) send_printable();
          sent += len;
        end else begin
          if (r < 480)
            send_printable();
          else if (r < 620)
            send_item(OP_PUT, CH_NEWLINE, 11'($urandom_range(0, 2047)));
          else if (r < 700)
            send_item(OP_PUT, CH_BACKSPACE, 11'($urandom_range(0, 2047)));
          else if (r < 860) begin
            if ($urandom_range(0, 15) == 0)
              send_item(OP_READ, 8'($urandom_range(0, 255)),
                        11'($urandom_range(CELLS, 2047)));
            else
              send_item(OP_READ, 8'($urandom_range(0, 255)),
                        11'($urandom_range(0, CELLS - 1)));
          end else if (r < 862)
            send_item(OP_CLEAR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
          else if (r < 890)
            send_item(OP_UNUSED, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
          else begin
            // noise: any fields, clears kept rare so the cursor reaches the bottom
            op = 2'($urandom_range(0, 3));
            if (op == OP_CLEAR && $urandom_range(0, 15) != 0) op = OP_UNUSED;
            send_item(op, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
          end
          sent++;
        end
      end
      no_idle = 1'b0;
    end

    // Drain
    wait_idle();
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.expected_reports.size() == 0)
      $display("** text_console_writer: PASSED **");
    else
      $display("** text_console_writer: FAILED **");
    $finish;
  end

endmodule

// File: files.f
hdl/tcw_pkg.sv
hdl/tcw_screen_ram.sv
hdl/tcw_sequencer.sv
hdl/text_console_writer.sv
tb/text_console_writer_tb.sv
